// File: src/dspin_pkg.sv
// Shared types, codes and helpers for the disk drive spindle controller.
// No dependencies; every other file refers to this package by scoped names.
package dspin_pkg;

   // Countdown timer width in bits.
   localparam int TIME_BITS = 16;
   localparam longint unsigned TIME_MAX = (64'd1 << TIME_BITS) - 64'd1;

   // Register file geometry: one register per 32-bit word.
   localparam int ADDR_BITS = 3;
   localparam int DATA_BITS = 32;
   localparam logic REG_SPIN_TIME     = 1'b0;
   localparam logic REG_WRITE_PROTECT = 1'b1;
   localparam logic [15:0] SPIN_TIME_RESET = 16'd1000;

   typedef enum logic [2:0] {
      OP_TICK       = 3'd0,
      OP_POWER_ON   = 3'd1,
      OP_POWER_OFF  = 3'd2,
      OP_SPIN_UP    = 3'd3,
      OP_SPIN_DOWN  = 3'd4,
      OP_SEEK       = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      MODE_OFF       = 3'd0,
      MODE_UNLOADED  = 3'd1,
      MODE_SPIN_UP   = 3'd2,
      MODE_LOCKED    = 3'd3,
      MODE_SEEKING   = 3'd4,
      MODE_SPIN_DOWN = 3'd5,
      MODE_EMERGENCY = 3'd6
   } mode_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [15:0] seek_time;
      logic        run_switch_up;
   } req_type;

   typedef struct packed {
      logic [2:0] drive_state;
      logic       power_lamp;
      logic       load_lamp;
      logic       ready_lamp;
      logic       on_cylinder_lamp;
      logic       protect_lamp;
      logic       drive_ready;
      logic       seek_ready;
      logic       seek_done;
   } rsp_type;

   typedef struct packed {
      logic [15:0] spin_time;
      logic        write_protect;
   } cfg_type;

   typedef struct packed {
      logic power;
      logic load;
      logic ready;
      logic on_cylinder;
      logic protect;
   } lamps_type;

   typedef struct packed {
      logic drive_ready;
      logic seek_ready;
   } status_type;

   // Clamp a 16-bit duration to the timer range.
   function automatic logic [TIME_BITS-1:0] sat_time(input logic [15:0] ticks);
      logic [63:0] wide;
      wide = 64'(ticks);
      if (wide > TIME_MAX) begin
         return '1;
      end
      return TIME_BITS'(wide);
   endfunction

endpackage

// File: src/dspin_csr.sv
// Configuration registers of the spindle controller on an APB-style port.
// Depends on dspin_pkg.
module dspin_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [dspin_pkg::ADDR_BITS-1:0]      paddr,
   input  logic [dspin_pkg::DATA_BITS-1:0]      pwdata,
   output logic [dspin_pkg::DATA_BITS-1:0]      prdata,
   output logic                                 pready,
   output dspin_pkg::cfg_type                   cfg
);

   logic [15:0] spin_time_ff;
   logic        write_protect_ff;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   // Word index sits at bit 2; byte offset bits are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         spin_time_ff     <= dspin_pkg::SPIN_TIME_RESET;
         write_protect_ff <= 1'b0;
      end else if (wr_en) begin
         unique case (paddr[2])
            dspin_pkg::REG_SPIN_TIME:     spin_time_ff     <= pwdata[15:0];
            dspin_pkg::REG_WRITE_PROTECT: write_protect_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         dspin_pkg::REG_SPIN_TIME:     prdata = {16'd0, spin_time_ff};
         dspin_pkg::REG_WRITE_PROTECT: prdata = {31'd0, write_protect_ff};
         default:                      prdata = '0;
      endcase
   end

   assign cfg.spin_time     = spin_time_ff;
   assign cfg.write_protect = write_protect_ff;

endmodule

// File: src/dspin_core.sv
// Drive mode machine, countdown timer, lamps and status bits.
// Depends on dspin_pkg; state advances on each word that reaches it.
module dspin_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  dspin_pkg::req_type   item,
   input  dspin_pkg::cfg_type   cfg,
   output dspin_pkg::rsp_type   rsp
);

   dspin_pkg::mode_type                 mode_ff, mode_in;
   logic [dspin_pkg::TIME_BITS-1:0]     count_ff, count_in;
   logic                                running_ff, running_in;
   dspin_pkg::lamps_type                lamps_ff, lamps_in;
   dspin_pkg::status_type               status_ff, status_in;
   logic                                done;
   logic                                expired;
   logic [dspin_pkg::TIME_BITS-1:0]     spin_full;
   logic [dspin_pkg::TIME_BITS-1:0]     spin_half;
   dspin_pkg::op_type                   op;

   assign op        = dspin_pkg::op_type'(item.operation);
   assign expired   = running_ff && (count_ff <= dspin_pkg::TIME_BITS'(1));
   assign spin_full = dspin_pkg::sat_time(cfg.spin_time);
   assign spin_half = dspin_pkg::sat_time(cfg.spin_time >> 1);

   // Next mode.
   always_comb begin
      mode_in = mode_ff;
      unique case (op)
         dspin_pkg::OP_TICK: begin
            if (expired) begin
               case (mode_ff)
                  dspin_pkg::MODE_SPIN_UP,
                  dspin_pkg::MODE_SEEKING:   mode_in = dspin_pkg::MODE_LOCKED;
                  dspin_pkg::MODE_SPIN_DOWN: mode_in = dspin_pkg::MODE_UNLOADED;
                  dspin_pkg::MODE_EMERGENCY: mode_in = dspin_pkg::MODE_OFF;
                  default: ;
               endcase
            end
         end
         dspin_pkg::OP_POWER_ON: begin
            if (mode_ff == dspin_pkg::MODE_OFF || mode_ff == dspin_pkg::MODE_EMERGENCY) begin
               if (!item.run_switch_up) begin
                  mode_in = dspin_pkg::MODE_UNLOADED;
               end else if (cfg.spin_time == 16'd0) begin
                  mode_in = dspin_pkg::MODE_LOCKED;
               end else begin
                  mode_in = dspin_pkg::MODE_SPIN_UP;
               end
            end
         end
         dspin_pkg::OP_POWER_OFF: begin
            case (mode_ff)
               dspin_pkg::MODE_UNLOADED:  mode_in = dspin_pkg::MODE_OFF;
               dspin_pkg::MODE_SPIN_UP,
               dspin_pkg::MODE_SPIN_DOWN,
               dspin_pkg::MODE_LOCKED,
               dspin_pkg::MODE_SEEKING:   mode_in = dspin_pkg::MODE_EMERGENCY;
               default: ;
            endcase
         end
         dspin_pkg::OP_SPIN_UP: begin
            if (mode_ff == dspin_pkg::MODE_UNLOADED || mode_ff == dspin_pkg::MODE_SPIN_DOWN) begin
               mode_in = dspin_pkg::MODE_SPIN_UP;
            end
         end
         dspin_pkg::OP_SPIN_DOWN: begin
            if (mode_ff == dspin_pkg::MODE_SPIN_UP || mode_ff == dspin_pkg::MODE_LOCKED ||
                mode_ff == dspin_pkg::MODE_SEEKING) begin
               mode_in = dspin_pkg::MODE_SPIN_DOWN;
            end
         end
         dspin_pkg::OP_SEEK: begin
            if (mode_ff == dspin_pkg::MODE_LOCKED) begin
               mode_in = dspin_pkg::MODE_SEEKING;
            end
         end
         default: ;
      endcase
   end

   // Timer, lamps, status bits and seek-done pulse.
   always_comb begin
      count_in   = count_ff;
      running_in = running_ff;
      lamps_in   = lamps_ff;
      status_in  = status_ff;
      done       = 1'b0;
      unique case (op)
         dspin_pkg::OP_TICK: begin
            if (expired) begin
               running_in = 1'b0;
               count_in   = '0;
               case (mode_ff)
                  dspin_pkg::MODE_SPIN_UP: begin
                     status_in.drive_ready = 1'b1;
                     status_in.seek_ready  = 1'b1;
                     lamps_in.ready        = 1'b1;
                     lamps_in.on_cylinder  = 1'b1;
                  end
                  dspin_pkg::MODE_SEEKING: begin
                     status_in.seek_ready = 1'b1;
                     lamps_in.on_cylinder = 1'b1;
                     done                 = 1'b1;
                  end
                  dspin_pkg::MODE_SPIN_DOWN: lamps_in.load = 1'b1;
                  dspin_pkg::MODE_EMERGENCY: lamps_in = '0;
                  default: ;
               endcase
            end else if (running_ff) begin
               count_in = count_ff - dspin_pkg::TIME_BITS'(1);
            end
         end
         dspin_pkg::OP_POWER_ON: begin
            if (mode_ff == dspin_pkg::MODE_OFF || mode_ff == dspin_pkg::MODE_EMERGENCY) begin
               running_in       = 1'b0;
               count_in         = '0;
               lamps_in.power   = 1'b1;
               lamps_in.protect = cfg.write_protect;
               if (!item.run_switch_up) begin
                  lamps_in.load = 1'b1;
               end else if (cfg.spin_time == 16'd0) begin
                  status_in.drive_ready = 1'b1;
                  status_in.seek_ready  = 1'b1;
                  lamps_in.ready        = 1'b1;
                  lamps_in.on_cylinder  = 1'b1;
               end else begin
                  count_in   = spin_full;
                  running_in = 1'b1;
               end
            end
         end
         dspin_pkg::OP_POWER_OFF: begin
            case (mode_ff)
               dspin_pkg::MODE_UNLOADED: lamps_in = '0;
               dspin_pkg::MODE_SPIN_UP,
               dspin_pkg::MODE_SPIN_DOWN,
               dspin_pkg::MODE_LOCKED,
               dspin_pkg::MODE_SEEKING: begin
                  // Emergency: lamps dark, keep a spin timer running, drop a seek timer.
                  lamps_in              = '0;
                  status_in.drive_ready = 1'b0;
                  if (mode_ff == dspin_pkg::MODE_LOCKED) begin
                     status_in.seek_ready = 1'b0;
                  end
                  if (!running_ff || mode_ff == dspin_pkg::MODE_SEEKING) begin
                     count_in   = spin_half;
                     running_in = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         dspin_pkg::OP_SPIN_UP: begin
            if (mode_ff == dspin_pkg::MODE_UNLOADED || mode_ff == dspin_pkg::MODE_SPIN_DOWN) begin
               if (mode_ff == dspin_pkg::MODE_UNLOADED) begin
                  lamps_in.load = 1'b0;
               end
               count_in   = spin_full;
               running_in = 1'b1;
            end
         end
         dspin_pkg::OP_SPIN_DOWN: begin
            if (mode_ff == dspin_pkg::MODE_SPIN_UP || mode_ff == dspin_pkg::MODE_LOCKED ||
                mode_ff == dspin_pkg::MODE_SEEKING) begin
               status_in.drive_ready = 1'b0;
               lamps_in.ready        = 1'b0;
               running_in            = 1'b1;
               if (mode_ff == dspin_pkg::MODE_LOCKED) begin
                  status_in.seek_ready = 1'b0;
                  lamps_in.on_cylinder = 1'b0;
                  count_in             = spin_full;
               end else begin
                  count_in = spin_half;
               end
            end
         end
         dspin_pkg::OP_SEEK: begin
            if (mode_ff == dspin_pkg::MODE_LOCKED) begin
               status_in.seek_ready = 1'b0;
               lamps_in.on_cylinder = 1'b0;
               count_in             = dspin_pkg::sat_time(item.seek_time);
               running_in           = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= dspin_pkg::MODE_OFF;
         count_ff   <= '0;
         running_ff <= 1'b0;
         lamps_ff   <= '0;
         status_ff  <= '0;
      end else if (go) begin
         mode_ff    <= mode_in;
         count_ff   <= count_in;
         running_ff <= running_in;
         lamps_ff   <= lamps_in;
         status_ff  <= status_in;
      end
   end

   assign rsp.drive_state      = 3'(mode_in);
   assign rsp.power_lamp       = lamps_in.power;
   assign rsp.load_lamp        = lamps_in.load;
   assign rsp.ready_lamp       = lamps_in.ready;
   assign rsp.on_cylinder_lamp = lamps_in.on_cylinder;
   assign rsp.protect_lamp     = lamps_in.protect;
   assign rsp.drive_ready      = status_in.drive_ready;
   assign rsp.seek_ready       = status_in.seek_ready;
   assign rsp.seek_done        = done;

endmodule

// File: src/disk_drive_spindle_fsm.sv
// Top level of the disk drive spindle and front-panel controller.
// Depends on dspin_pkg, dspin_csr and dspin_core.
//
// Usage:
//  - req channel (req_valid/req_ready/req_data): one word per event, carrying
//    the operation (tick, power on/off, spin up/down, seek), the seek time and
//    the run switch position.
//  - rsp channel (rsp_valid/rsp_ready/rsp_data): exactly one word per request
//    word: drive mode, five lamps, drive-ready, seek-ready and seek-done pulse.
//  - APB-style port: spin_time at byte address 0, write_protect at 4.
//    pready is tied high; write only while the block is idle.
// Timing: a request word lands in the input register on its accept edge; the
//  first edge with the result register free runs the mode machine and loads
//  it, raising rsp_valid. One word per cycle sustained while rsp_ready is high;
//  the mode machine state update is the single step that sets this rate.
// Reset: synchronous, active high; drive powered off, timer stopped, lamps
//  off, spin_time 1000, write_protect 0.
// Backpressure: with rsp_ready low the result holds and the input register
//  still takes one more word; req_ready drops only when both stages are full.
module disk_drive_spindle_fsm (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  dspin_pkg::req_type               req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output dspin_pkg::rsp_type               rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [dspin_pkg::ADDR_BITS-1:0]  paddr,
   input  logic [dspin_pkg::DATA_BITS-1:0]  pwdata,
   output logic [dspin_pkg::DATA_BITS-1:0]  prdata,
   output logic                             pready
);

   dspin_pkg::cfg_type  cfg;
   dspin_pkg::req_type  in_item_ff;
   logic                in_valid_ff;
   dspin_pkg::rsp_type  rsp_item_ff;
   dspin_pkg::rsp_type  core_rsp;
   logic                rsp_valid_ff;
   logic                advance;

   dspin_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Move the held word into the result register when that register is free.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   dspin_core u_core (
      .clock (clock),
      .reset (reset),
      .go    (advance),
      .item  (in_item_ff),
      .cfg   (cfg),
      .rsp   (core_rsp)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_item_ff <= req_data;
      end
   end

   // Result register: hold while the receiver stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= core_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_item_ff;

   // A completed seek always leaves the drive locked on cylinder.
   a_seek_done_locked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.seek_done |->
         rsp_data.drive_state == 3'(dspin_pkg::MODE_LOCKED))
      else $error("seek_done outside locked mode");

   // On-cylinder lamp and seek-ready status move together.
   a_oncyl_seek_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.on_cylinder_lamp == rsp_data.seek_ready)
      else $error("on-cylinder lamp and seek_ready disagree");

   // The ready lamp can only be lit on a powered drive.
   a_ready_needs_power: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.ready_lamp |-> rsp_data.power_lamp)
      else $error("ready lamp lit without power lamp");

   // Powered off means every lamp is dark.
   a_off_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.drive_state == 3'(dspin_pkg::MODE_OFF) |->
         !(rsp_data.power_lamp || rsp_data.load_lamp || rsp_data.ready_lamp ||
           rsp_data.on_cylinder_lamp || rsp_data.protect_lamp))
      else $error("lamp lit while powered off");

endmodule

// File: sim/spindle_mode_check.sv
`timescale 1ns / 1ps
// Result checker for the disk drive spindle controller: follows register writes, predicts
// each status word with its own copy of the mode machine and compares results in order.
// Depends on dspin_pkg.
module spindle_mode_check (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  dspin_pkg::req_type              req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  dspin_pkg::rsp_type              rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [dspin_pkg::ADDR_BITS-1:0] paddr,
   input  logic [dspin_pkg::DATA_BITS-1:0] pwdata,
   input  logic                            pready,
   output int                              outstanding,
   output int                              mismatches,
   output int                              seeks_done
);

   localparam int PRINT_CAP = 40;

   logic [15:0]           spin_len;
   logic                  protect_cfg;
   dspin_pkg::mode_type   drive_mode;
   logic [15:0]           ticks_left;
   logic                  timer_on;
   dspin_pkg::lamps_type  lamp_set;
   dspin_pkg::status_type status_set;
   dspin_pkg::rsp_type    status_due[$];
   int                    result_no;
   int                    bad_count;
   int                    done_count;

   assign mismatches = bad_count;
   assign seeks_done = done_count;

   task automatic report(input string msg);
      if (bad_count < PRINT_CAP) begin
         $display("[%0t] result %0d: %s", $realtime, result_no, msg);
      end
      bad_count++;
   endtask

   task automatic check_field(input string what, input logic [2:0] got, input logic [2:0] want);
      if (got !== want) begin
         report($sformatf("%s got %b expected %b", what, got, want));
      end
   endtask

   task automatic arm_timer(input logic [15:0] ticks);
      ticks_left = ticks;
      timer_on   = 1'b1;
   endtask

   task automatic halt_timer();
      timer_on   = 1'b0;
      ticks_left = '0;
   endtask

   task automatic lock_on();
      lamp_set.on_cylinder  = 1'b1;
      status_set.seek_ready = 1'b1;
      drive_mode            = dspin_pkg::MODE_LOCKED;
   endtask

   task automatic become_ready();
      status_set.drive_ready = 1'b1;
      lamp_set.ready         = 1'b1;
      lock_on();
   endtask

   task automatic unlock();
      lamp_set.on_cylinder  = 1'b0;
      status_set.seek_ready = 1'b0;
   endtask

   task automatic start_spin_down(input logic [15:0] ticks);
      arm_timer(ticks);
      status_set.drive_ready = 1'b0;
      lamp_set.ready         = 1'b0;
      drive_mode             = dspin_pkg::MODE_SPIN_DOWN;
   endtask

   // A spin timer already running keeps going; otherwise wait half a spin time.
   task automatic go_emergency();
      lamp_set               = '0;
      status_set.drive_ready = 1'b0;
      if (!timer_on) begin
         arm_timer(spin_len >> 1);
      end
      drive_mode = dspin_pkg::MODE_EMERGENCY;
   endtask

   task automatic go_off();
      lamp_set   = '0;
      drive_mode = dspin_pkg::MODE_OFF;
   endtask

   // Apply one request word to the predicted drive and build its status word.
   task automatic advance_drive(input dspin_pkg::req_type w, output dspin_pkg::rsp_type r);
      logic done;
      done = 1'b0;
      case (w.operation)
         dspin_pkg::OP_TICK: begin
            if (timer_on) begin
               if (ticks_left <= 16'd1) begin
                  halt_timer();
                  case (drive_mode)
                     dspin_pkg::MODE_SPIN_UP:   become_ready();
                     dspin_pkg::MODE_SEEKING: begin
                        lock_on();
                        done = 1'b1;
                     end
                     dspin_pkg::MODE_SPIN_DOWN: begin
                        lamp_set.load = 1'b1;
                        drive_mode    = dspin_pkg::MODE_UNLOADED;
                     end
                     dspin_pkg::MODE_EMERGENCY: go_off();
                     default: ;
                  endcase
               end else begin
                  ticks_left = ticks_left - 16'd1;
               end
            end
         end
         dspin_pkg::OP_POWER_ON: begin
            if (drive_mode == dspin_pkg::MODE_OFF ||
                drive_mode == dspin_pkg::MODE_EMERGENCY) begin
               halt_timer();
               lamp_set.power   = 1'b1;
               lamp_set.protect = protect_cfg;
               if (w.run_switch_up) begin
                  if (spin_len == 16'd0) begin
                     become_ready();
                  end else begin
                     arm_timer(spin_len);
                     drive_mode = dspin_pkg::MODE_SPIN_UP;
                  end
               end else begin
                  lamp_set.load = 1'b1;
                  drive_mode    = dspin_pkg::MODE_UNLOADED;
               end
            end
         end
         dspin_pkg::OP_POWER_OFF: begin
            case (drive_mode)
               dspin_pkg::MODE_UNLOADED: go_off();
               dspin_pkg::MODE_SPIN_UP,
               dspin_pkg::MODE_SPIN_DOWN: go_emergency();
               dspin_pkg::MODE_LOCKED: begin
                  unlock();
                  go_emergency();
               end
               dspin_pkg::MODE_SEEKING: begin
                  halt_timer();
                  go_emergency();
               end
               default: ;
            endcase
         end
         dspin_pkg::OP_SPIN_UP: begin
            if (drive_mode == dspin_pkg::MODE_UNLOADED ||
                drive_mode == dspin_pkg::MODE_SPIN_DOWN) begin
               if (drive_mode == dspin_pkg::MODE_UNLOADED) begin
                  lamp_set.load = 1'b0;
               end
               arm_timer(spin_len);
               drive_mode = dspin_pkg::MODE_SPIN_UP;
            end
         end
         dspin_pkg::OP_SPIN_DOWN: begin
            case (drive_mode)
               dspin_pkg::MODE_SPIN_UP,
               dspin_pkg::MODE_SEEKING: start_spin_down(spin_len >> 1);
               dspin_pkg::MODE_LOCKED: begin
                  unlock();
                  start_spin_down(spin_len);
               end
               default: ;
            endcase
         end
         dspin_pkg::OP_SEEK: begin
            if (drive_mode == dspin_pkg::MODE_LOCKED) begin
               unlock();
               arm_timer(w.seek_time);
               drive_mode = dspin_pkg::MODE_SEEKING;
            end
         end
         default: ;
      endcase
      r.drive_state      = drive_mode;
      r.power_lamp       = lamp_set.power;
      r.load_lamp        = lamp_set.load;
      r.ready_lamp       = lamp_set.ready;
      r.on_cylinder_lamp = lamp_set.on_cylinder;
      r.protect_lamp     = lamp_set.protect;
      r.drive_ready      = status_set.drive_ready;
      r.seek_ready       = status_set.seek_ready;
      r.seek_done        = done;
   endtask

   always @(posedge clock) begin
      dspin_pkg::rsp_type want;
      if (reset) begin
         spin_len    = dspin_pkg::SPIN_TIME_RESET;
         protect_cfg = 1'b0;
         drive_mode  = dspin_pkg::MODE_OFF;
         halt_timer();
         lamp_set    = '0;
         status_set  = '0;
         status_due.delete();
         result_no   = 0;
         bad_count   = 0;
         done_count  = 0;
         outstanding <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == {dspin_pkg::REG_SPIN_TIME, 2'b00}) begin
               spin_len = pwdata[15:0];
            end else if (paddr == {dspin_pkg::REG_WRITE_PROTECT, 2'b00}) begin
               protect_cfg = pwdata[0];
            end
         end
         if (req_valid && req_ready) begin
            advance_drive(req_data, want);
            status_due.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (status_due.size() == 0) begin
               report("result word with nothing expected");
            end else begin
               want = status_due.pop_front();
               check_field("drive_state", rsp_data.drive_state, want.drive_state);
               check_field("power_lamp", 3'(rsp_data.power_lamp), 3'(want.power_lamp));
               check_field("load_lamp", 3'(rsp_data.load_lamp), 3'(want.load_lamp));
               check_field("ready_lamp", 3'(rsp_data.ready_lamp), 3'(want.ready_lamp));
               check_field("on_cylinder_lamp", 3'(rsp_data.on_cylinder_lamp),
                           3'(want.on_cylinder_lamp));
               check_field("protect_lamp", 3'(rsp_data.protect_lamp), 3'(want.protect_lamp));
               check_field("drive_ready", 3'(rsp_data.drive_ready), 3'(want.drive_ready));
               check_field("seek_ready", 3'(rsp_data.seek_ready), 3'(want.seek_ready));
               check_field("seek_done", 3'(rsp_data.seek_done), 3'(want.seek_done));
               if (want.seek_done) begin
                  done_count++;
               end
            end
            result_no++;
         end
         outstanding <= status_due.size();
      end
   end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Testbench top for disk_drive_spindle_fsm: clock, reset, register writes and request
// words; result checking lives in spindle_mode_check. Depends on dspin_pkg and the RTL.
module tb;

   // Operation codes the block has no use for; it must leave the drive alone.
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;
   localparam int IDLE_LIMIT  = 2000;
   localparam int PHASES      = 8;
   localparam int PHASE_WORDS = 225;

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   dspin_pkg::req_type              req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b1;
   dspin_pkg::rsp_type              rsp_data;
   logic                            psel      = 1'b0;
   logic                            penable   = 1'b0;
   logic                            pwrite    = 1'b0;
   logic [dspin_pkg::ADDR_BITS-1:0] paddr     = '0;
   logic [dspin_pkg::DATA_BITS-1:0] pwdata    = '0;
   logic [dspin_pkg::DATA_BITS-1:0] prdata;
   logic                            pready;
   int                              outstanding;
   int                              mismatches;
   int                              seeks_done;

   int          send_gap_pct  = 0;
   int          stall_pct     = 0;
   int          stall_left    = 0;
   int          idle_cycles   = 0;
   int          words_sent    = 0;
   int          settings_used = 0;
   logic        quiet         = 1'b0;
   logic [15:0] spin_setting  = dspin_pkg::SPIN_TIME_RESET;

   disk_drive_spindle_fsm dut (.*);

   spindle_mode_check checker_i (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // Receiver: drop ready in random bursts, started with probability stall_pct percent.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!reset && $urandom_range(0, 99) < stall_pct) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: end the run if neither channel moves a word for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("disk_drive_spindle_fsm: mismatch");
         $finish;
      end
   end

   // Present one request word, with an optional gap ahead of it, and hold it
   // until the accept edge.
   task automatic send(input logic [2:0] op, input logic [15:0] seek_ticks, input logic run_up);
      int gap;
      gap = (!quiet && $urandom_range(0, 99) < send_gap_pct) ? $urandom_range(1, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{operation: op, seek_time: seek_ticks, run_switch_up: run_up};
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   // Hold off the sender until every predicted word has come back, then let
   // the result stage settle.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (3) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the register takes the data at the access edge.
   task automatic write_reg(input logic idx, input logic [dspin_pkg::DATA_BITS-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_config(input logic [15:0] spin, input logic protect);
      drain();
      write_reg(dspin_pkg::REG_SPIN_TIME, dspin_pkg::DATA_BITS'(spin));
      write_reg(dspin_pkg::REG_WRITE_PROTECT, dspin_pkg::DATA_BITS'(protect));
      spin_setting = spin;
      settings_used++;
   endtask

   function automatic logic [2:0] pick_event();
      int r;
      r = $urandom_range(0, 99);
      if (r < 16) return dspin_pkg::OP_POWER_ON;
      if (r < 30) return dspin_pkg::OP_POWER_OFF;
      if (r < 45) return dspin_pkg::OP_SPIN_UP;
      if (r < 60) return dspin_pkg::OP_SPIN_DOWN;
      if (r < 94) return dspin_pkg::OP_SEEK;
      return ($urandom_range(0, 1) != 0) ? OP_SPARE_7 : OP_SPARE_6;
   endfunction

   function automatic logic [15:0] pick_seek();
      if ($urandom_range(0, 99) < 85) return 16'($urandom_range(0, 6));
      return 16'($urandom_range(0, 65535));
   endfunction

   initial begin
      logic [15:0] spins [PHASES];
      logic        protects [PHASES];
      int          n;
      int          burst;
      int          cap;
      logic        held;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed walk through every mode with a two-tick spin time.
      set_config(16'd2, 1'b1);
      send(dspin_pkg::OP_TICK, 16'hFFFF, 1'b1);     // off with no timer: nothing moves
      send(OP_SPARE_6, 16'h0000, 1'b0);
      send(OP_SPARE_7, 16'hFFFF, 1'b1);
      send(dspin_pkg::OP_POWER_ON, 16'h0000, 1'b0); // switch down: unloaded, protect lit
      send(dspin_pkg::OP_SEEK, 16'd5, 1'b0);        // unhandled while unloaded
      send(dspin_pkg::OP_SPIN_UP, 16'h0000, 1'b0);
      send(dspin_pkg::OP_SPIN_DOWN, 16'h0000, 1'b0); // half spin time from spin up
      send(dspin_pkg::OP_SPIN_UP, 16'h0000, 1'b0);   // back up, full spin time again
      send(dspin_pkg::OP_TICK, 16'h0000, 1'b0);
      send(dspin_pkg::OP_TICK, 16'h0000, 1'b0);     // locked on
      send(dspin_pkg::OP_SEEK, 16'd0, 1'b0);        // zero seek ends on the next tick
      send(dspin_pkg::OP_TICK, 16'h0000, 1'b0);
      send(dspin_pkg::OP_SEEK, 16'hFFFF, 1'b0);
      send(dspin_pkg::OP_SPIN_DOWN, 16'h0000, 1'b0); // seek timer dropped for half spin
      send(dspin_pkg::OP_TICK, 16'h0000, 1'b0);     // unloaded
      send(dspin_pkg::OP_POWER_OFF, 16'h0000, 1'b0);
      send(dspin_pkg::OP_POWER_ON, 16'h0000, 1'b1);
      send(dspin_pkg::OP_POWER_OFF, 16'h0000, 1'b1); // emergency keeps the spin timer
      send(dspin_pkg::OP_TICK, 16'h0000, 1'b1);
      send(dspin_pkg::OP_POWER_ON, 16'h0000, 1'b1);  // restart out of emergency
      send(dspin_pkg::OP_TICK, 16'h0000, 1'b1);
      send(dspin_pkg::OP_TICK, 16'h0000, 1'b1);
      send(dspin_pkg::OP_SEEK, 16'd3, 1'b1);
      send(dspin_pkg::OP_POWER_OFF, 16'h0000, 1'b1); // seek cancelled, half spin loaded
      send(dspin_pkg::OP_TICK, 16'h0000, 1'b1);

      // Zero spin time: lock on at power on, timers expire on the next tick.
      set_config(16'd0, 1'b0);
      send(dspin_pkg::OP_POWER_ON, 16'h0000, 1'b1);
      send(dspin_pkg::OP_SPIN_DOWN, 16'h0000, 1'b1);
      send(dspin_pkg::OP_TICK, 16'h0000, 1'b1);
      send(dspin_pkg::OP_SPIN_UP, 16'h0000, 1'b1);
      send(dspin_pkg::OP_TICK, 16'h0000, 1'b1);
      send(dspin_pkg::OP_POWER_OFF, 16'h0000, 1'b1);
      send(dspin_pkg::OP_TICK, 16'h0000, 1'b1);

      // Random phases; each one runs under its own register setting.
      spins    = '{16'd1, 16'd0, 16'hFFFF, 16'($urandom_range(2, 10)), 16'd5,
                   16'($urandom_range(1, 30)), 16'd3, 16'd2};
      protects = '{1'b0, 1'b1, 1'b1, 1'($urandom_range(0, 1)), 1'b0,
                   1'($urandom_range(0, 1)), 1'b1, 1'b0};
      for (int p = 0; p < PHASES; p++) begin
         set_config(spins[p], protects[p]);
         // Phase 2 and the closing phase run with no random send gaps or receiver stalls.
         if (p == 2 || p == PHASES - 1) begin
            send_gap_pct = 0;
            stall_pct   <= 0;
            quiet        = (p == PHASES - 1);
         end else begin
            send_gap_pct = 25;
            stall_pct   <= 25;
         end
         n    = 0;
         held = 1'b0;
         while (n < PHASE_WORDS) begin
            if (!held && !quiet && n >= PHASE_WORDS / 2) begin
               drain();
               held = 1'b1;
            end
            // Tick runs of 1 to min(spin setting, 24) + 2 words; otherwise one event.
            if ($urandom_range(0, 99) < 35) begin
               cap   = (spin_setting > 16'd24) ? 24 : int'(spin_setting);
               burst = $urandom_range(1, cap + 2);
               repeat (burst) begin
                  send(dspin_pkg::OP_TICK, 16'($urandom), 1'($urandom_range(0, 1)));
               end
               n += burst;
            end else begin
               send(pick_event(), pick_seek(), $urandom_range(0, 3) != 0);
               n++;
            end
         end
      end

      drain();
      repeat (4) @(posedge clock);
      $display("Sent %0d request words under %0d register settings; %0d seeks completed.",
               words_sent, settings_used, seeks_done);
      if (mismatches == 0) begin
         $display("disk_drive_spindle_fsm: match");
      end else begin
         $display("disk_drive_spindle_fsm: mismatch");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/dspin_pkg.sv
src/dspin_csr.sv
src/dspin_core.sv
src/disk_drive_spindle_fsm.sv
sim/spindle_mode_check.sv
sim/tb.sv
